// File: rtl/core/sha1_pkg.sv
package sha1_pkg;

    localparam int WORD_W       = 32;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 5;
    localparam int INDEX_W      = 3;
    localparam int COUNT_W      = 4;
    localparam int ROUND_W      = 7;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [COUNT_W-1:0] LAST_WORD     = COUNT_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND    = ROUND_W'(79);
    localparam logic [ROUND_W-1:0] PHASE1_START  = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] PHASE2_START  = ROUND_W'(40);
    localparam logic [ROUND_W-1:0] PHASE3_START  = ROUND_W'(60);
    localparam logic [INDEX_W-1:0] LAST_INDEX    = INDEX_W'(DIGEST_WORDS - 1);

    localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              restart;
        logic              first;
        logic              last;
    } msg_entry_t;

    typedef enum logic [1:0] {
        ENG_ABSORB,
        ENG_ROUNDS,
        ENG_UPDATE,
        ENG_EMIT
    } eng_state_t;

    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < PHASE1_START)
            k = K0;
        else if (rnd < PHASE2_START)
            k = K1;
        else if (rnd < PHASE3_START)
            k = K2;
        else
            k = K3;
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(
        input logic [ROUND_W-1:0] rnd,
        input logic [WORD_W-1:0]  b,
        input logic [WORD_W-1:0]  c,
        input logic [WORD_W-1:0]  d
    );
        logic [WORD_W-1:0] f;
        if (rnd < PHASE1_START)
            f = (b & c) | (~b & d);
        else if (rnd < PHASE2_START)
            f = b ^ c ^ d;
        else if (rnd < PHASE3_START)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

// File: rtl/core/sha1_front.sv
module sha1_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sha1_pkg::WORD_W-1:0]   in_word,
    input  logic                          in_restart,
    output logic                          push_valid,
    input  logic                          push_ready,
    output sha1_pkg::msg_entry_t          push_entry
);

    logic [sha1_pkg::COUNT_W-1:0] word_count_reg;
    logic [sha1_pkg::COUNT_W-1:0] word_count_next;
    logic                         first_word;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign first_word = (word_count_reg == '0);

    // the restart flag counts only on the first word of a block
    always_comb
    begin
        push_entry.word    = in_word;
        push_entry.first   = first_word;
        push_entry.last    = (word_count_reg == sha1_pkg::LAST_WORD);
        push_entry.restart = first_word & in_restart;
    end

    always_comb
    begin
        word_count_next = word_count_reg;
        if (in_valid && push_ready)
            word_count_next = word_count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_count_reg <= '0;
        else
            word_count_reg <= word_count_next;
    end

endmodule

// File: rtl/core/sha1_queue.sv
module sha1_queue
#(
    parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sha1_pkg::msg_entry_t push_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sha1_pkg::msg_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sha1_pkg::msg_entry_t entries_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: rtl/core/sha1_engine.sv
module sha1_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  sha1_pkg::msg_entry_t          pop_entry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sha1_pkg::WORD_W-1:0]   out_word,
    output logic [sha1_pkg::INDEX_W-1:0]  out_index,
    output logic                          out_last
);

    localparam int W  = sha1_pkg::WORD_W;
    localparam int NB = sha1_pkg::BLOCK_WORDS;
    localparam int ND = sha1_pkg::DIGEST_WORDS;

    sha1_pkg::eng_state_t state_reg, state_next;

    logic [sha1_pkg::ROUND_W-1:0] rnd_reg, rnd_next;
    logic [sha1_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic [W-1:0] h_reg [ND];
    logic [W-1:0] h_next [ND];
    logic [W-1:0] w_reg [NB];
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [W-1:0] a_next, b_next, c_next, d_next, e_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] out_word_reg;
    logic [sha1_pkg::INDEX_W-1:0] out_index_reg;
    logic         out_last_reg;

    logic         pop;
    logic         do_round;
    logic         load_out;
    logic [W-1:0] ca, cb, cc, cd, ce;
    logic [W-1:0] w_mix, w_expanded, w_in, t_sum;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

    assign pop_ready = (state_reg == sha1_pkg::ENG_ABSORB);
    assign pop       = pop_valid && pop_ready;
    assign do_round  = pop || (state_reg == sha1_pkg::ENG_ROUNDS);
    assign load_out  = (state_reg == sha1_pkg::ENG_EMIT) && (!out_valid_reg || out_ready);

    // w_reg[0] is w[t-16], w_reg[15] is w[t-1]
    assign w_mix      = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_expanded = {w_mix[W-2:0], w_mix[W-1]};
    assign w_in       = (state_reg == sha1_pkg::ENG_ABSORB) ? pop_entry.word : w_expanded;

    // the first word of a block starts the rounds from the chaining value, or from the initial value on restart
    always_comb
    begin
        if (state_reg == sha1_pkg::ENG_ABSORB && pop_entry.first)
        begin
            if (pop_entry.restart)
            begin
                ca = sha1_pkg::H_INIT[0];
                cb = sha1_pkg::H_INIT[1];
                cc = sha1_pkg::H_INIT[2];
                cd = sha1_pkg::H_INIT[3];
                ce = sha1_pkg::H_INIT[4];
            end
            else
            begin
                ca = h_reg[0];
                cb = h_reg[1];
                cc = h_reg[2];
                cd = h_reg[3];
                ce = h_reg[4];
            end
        end
        else
        begin
            ca = a_reg;
            cb = b_reg;
            cc = c_reg;
            cd = d_reg;
            ce = e_reg;
        end
    end

    assign t_sum = {ca[W-6:0], ca[W-1:W-5]}
                 + sha1_pkg::round_f(rnd_reg, cb, cc, cd)
                 + ce + w_in + sha1_pkg::round_k(rnd_reg);

    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        h_next         = h_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (do_round)
        begin
            a_next   = t_sum;
            b_next   = ca;
            c_next   = {cb[1:0], cb[W-1:2]};
            d_next   = cc;
            e_next   = cd;
            rnd_next = rnd_reg + 1'b1;
        end

        case (state_reg)
            sha1_pkg::ENG_ABSORB:
            begin
                if (pop)
                begin
                    if (pop_entry.restart)
                        h_next = sha1_pkg::H_INIT;
                    if (pop_entry.last)
                        state_next = sha1_pkg::ENG_ROUNDS;
                end
            end
            sha1_pkg::ENG_ROUNDS:
            begin
                if (rnd_reg == sha1_pkg::LAST_ROUND)
                    state_next = sha1_pkg::ENG_UPDATE;
            end
            sha1_pkg::ENG_UPDATE:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                idx_next   = '0;
                state_next = sha1_pkg::ENG_EMIT;
            end
            sha1_pkg::ENG_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == sha1_pkg::LAST_INDEX)
                    begin
                        rnd_next   = '0;
                        state_next = sha1_pkg::ENG_ABSORB;
                    end
                end
            end
            default:
            begin
                state_next = sha1_pkg::ENG_ABSORB;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ENG_ABSORB;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ND; i++)
                h_reg[i] <= sha1_pkg::H_INIT[i];
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        if (do_round)
        begin
            for (int i = 0; i < NB - 1; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[NB-1] <= w_in;
        end
        if (load_out)
        begin
            out_word_reg  <= h_reg[idx_reg];
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == sha1_pkg::LAST_INDEX);
        end
    end

endmodule

// File: rtl/core/sha1_block_compression.sv
// SHA-1 block compression.
// Input stream: one 32-bit message word per transfer, sixteen words to a
// block, most significant word first. tuser set on the first word of a
// block reloads the standard initial chaining value; on other words it is
// ignored. Padding and length fields are the sender's job.
// Output stream: after each block, five transfers carry the updated
// chaining words H0..H4; tuser gives the word index, tlast marks H4.
// Words pass through a small queue into the round engine, which runs one
// round per cycle: rounds 0..15 as the words arrive, rounds 16..79 from
// the sixteen-word schedule window, then the chaining add in its own state.
// The engine takes no new words from the queue until it has loaded the
// last digest word of a block for output; its throughput is set by the
// single shared round unit and the emit phase.
// The input keeps taking words into the queue while the engine is busy,
// and stops when the queue is full. A stalled output holds the current
// word and the engine waits in its emit phase.
// Reset loads the initial chaining value and starts a fresh block.
module sha1_block_compression
#(
    parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic        s_axis_tuser,   // [0] new_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] digest_index
    output logic        m_axis_tlast
);

    logic                 push_valid, push_ready;
    logic                 pop_valid, pop_ready;
    sha1_pkg::msg_entry_t push_entry, pop_entry;

    sha1_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    sha1_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    sha1_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: rtl/core/sha1_checker.sv
module sha1_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    localparam logic [2:0] LAST_IDX = 3'(sha1_pkg::DIGEST_WORDS - 1);

    // tlast sits on the final digest word and nowhere else
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == LAST_IDX)))
        else $error("tlast does not match the final digest index");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= LAST_IDX))
        else $error("digest index out of range");

    // the next digest word follows a non-final transfer at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1)))
        else $error("digest words out of sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output changed");

endmodule

bind sha1_block_compression sha1_checker u_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_WORDS = 487;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] RC [4] = '{
        32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
    };
    // published digest of the one-block message "abc"
    localparam logic [31:0] ABC_DIGEST [5] = '{
        32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d
    };

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS,
        FILL_WALK,
        FILL_SPARSE
    } fill_kind_t;

    typedef struct packed {
        logic [31:0] word;
        logic        restart;
        logic        typed_digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0]  chain_h [5];
    logic [31:0]  blk_w [16];
    logic [3:0]   blk_cnt;
    digest_beat_t digest_due [$];
    stim_row_t    dir_rows [$];
    int           fault_count;
    int           src_idle_pct;
    int           sink_stall_pct;

    sha1_block_compression dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] message_word
        .s_axis_tuser  (s_axis_tuser),   // [0] new_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] digest_word
        .m_axis_tuser  (m_axis_tuser),   // [2:0] digest_index
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_rounds();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, t;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk_w[i];
        for (i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
                f = (b & c) | (~b & d);
            else if (i < 40)
                f = b ^ c ^ d;
            else if (i < 60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            t = rol(a, 5) + f + e + w[i] + RC[i / 20];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // take one accepted word; queue the five digest words when a block closes
    function automatic void absorb_word(input logic [31:0] w, input logic restart,
                                        input logic typed_digest);
        int i;
        if (blk_cnt == 4'd0 && restart)
            chain_h = IV;
        blk_w[blk_cnt] = w;
        if (blk_cnt != 4'd15)
        begin
            blk_cnt++;
        end
        else
        begin
            blk_cnt = 4'd0;
            sha1_rounds();
            for (i = 0; i < 5; i++)
                digest_due.push_back('{typed_digest ? ABC_DIGEST[i] : chain_h[i],
                                       3'(i), i == 4});
        end
    endfunction

    task automatic send_word(input logic [31:0] w, input logic restart,
                             input logic typed_digest);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = w;
        s_axis_tuser  = restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        absorb_word(w, restart, typed_digest);
    endtask

    // hold the input idle until every digest word has come out
    task automatic drain_digests();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (digest_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] fill_word(input fill_kind_t kind);
        logic [31:0] w;
        case (kind)
            FILL_ONES:   w = 32'hffffffff;
            FILL_ZEROS:  w = 32'h00000000;
            FILL_WALK:   w = 32'h1 << $urandom_range(31);
            FILL_SPARSE: w = $urandom & $urandom & $urandom;
            default:     w = $urandom;
        endcase
        return w;
    endfunction

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        digest_beat_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digest_due.size() == 0)
            begin
                $display("%0t: unexpected digest transfer word=%h index=%0d last=%b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fault_count++;
            end
            else
            begin
                due = digest_due.pop_front();
                if (m_axis_tdata !== due.word)
                begin
                    $display("%0t: digest word expected %h actual %h",
                             $time, due.word, m_axis_tdata);
                    fault_count++;
                end
                if (m_axis_tuser !== due.index)
                begin
                    $display("%0t: digest index expected %0d actual %0d",
                             $time, due.index, m_axis_tuser);
                    fault_count++;
                end
                if (m_axis_tlast !== due.last)
                begin
                    $display("%0t: tlast expected %b actual %b",
                             $time, due.last, m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("sha1_block_compression: mismatch");
        $finish;
    end

    initial
    begin
        int         n;
        int         phase;
        int         pos;
        logic       restart;
        fill_kind_t kind;

        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fault_count    = 0;
        chain_h        = IV;
        blk_cnt        = 4'd0;
        kind           = FILL_RANDOM;

        // first block: padded "abc" straight from reset with no restart flag,
        // then a block opened with the flag and the flag again mid-block
        dir_rows = '{
            '{32'h61626380, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000000, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}, '{32'h00000018, 1'b0, 1'b1},
            '{32'hffffffff, 1'b1, 1'b0}, '{32'h00000000, 1'b1, 1'b0},
            '{32'hffffffff, 1'b0, 1'b0}, '{32'h80000000, 1'b0, 1'b0},
            '{32'h00000001, 1'b1, 1'b0}, '{32'haaaaaaaa, 1'b0, 1'b0},
            '{32'h55555555, 1'b0, 1'b0}, '{32'hffffffff, 1'b0, 1'b0},
            '{32'h00000000, 1'b0, 1'b0}
        };

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].restart, dir_rows[i].typed_digest);

        phase = 0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n * 4 / RANDOM_WORDS != phase)
            begin
                phase = n * 4 / RANDOM_WORDS;
                drain_digests();
                case (phase)
                    1:       begin src_idle_pct = 75; sink_stall_pct = 0;  end
                    2:       begin src_idle_pct = 0;  sink_stall_pct = 75; end
                    default: begin src_idle_pct = 17; sink_stall_pct = 17; end
                endcase
            end
            pos = (dir_rows.size() + n) % 16;
            if (pos == 0)
            begin
                case ($urandom_range(9))
                    6:       kind = FILL_ONES;
                    7:       kind = FILL_ZEROS;
                    8:       kind = FILL_WALK;
                    9:       kind = FILL_SPARSE;
                    default: kind = FILL_RANDOM;
                endcase
                restart = 1'($urandom_range(1));
            end
            else
            begin
                // stray flags inside a block must be dropped
                restart = ($urandom_range(9) == 0);
            end
            send_word(fill_word(kind), restart, 1'b0);
        end

        drain_digests();
        repeat (100) @(posedge clk);
        if (fault_count == 0)
            $display("sha1_block_compression: match");
        else
            $display("sha1_block_compression: mismatch");
        $finish;
    end

endmodule
